// ===== hw/rtl/rti_pkg.sv =====
package rti_pkg;

   // packed width of one vertex or vector field
   localparam int VEC_W = 48;
   // width and fraction bits of the hit distance and the limit
   localparam int DIST_W = 32;
   localparam int FRAC_W = 16;
   // stream payload widths, padded to whole bytes
   localparam int REQ_W = 5 * VEC_W + DIST_W;
   localparam int RSP_W = 40;

endpackage

// ===== hw/rtl/ray_triangle_intersect.sv =====
// Channel  Dir  Ports                          Contents
// req      in   req_tvalid/tready/tdata[271:0] triangle, ray and distance limit
// rsp      out  rsp_tvalid/tready/tdata[39:0]  hit flag and hit distance
//
// One item enters per cycle while req_tready is high. Results leave in order
// after 15 register stages in the geometry pipeline (edges, cross products,
// dot product multipliers, dot sums, edge multipliers, decision), one in the
// queue and 33 in the bit-per-stage divider.
// Reset is synchronous, active high, and empties both pipelines and the queue.
// A stalled result holds the divider only; the geometry side keeps taking
// items until the queue fills, and then req_tready drops.
module ray_triangle_intersect import rti_pkg::*; #(
   parameter int COORD_BITS  = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // vertex_a, vertex_b, vertex_c, ray_origin, ray_direction, max_distance
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit, distance, zero pad
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int NW  = 3 * COORD_BITS + 6;
   localparam int QDW = 1 + 2 * NW;

   // front to queue
   logic              f_valid;
   logic              f_hit;
   logic [NW-1:0]     f_num_mag;
   logic [NW-1:0]     f_den_mag;
   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   logic [QDW-1:0]    q_out;

   // divider side
   logic              d_ready;
   logic              d_hit;
   logic [DIST_W-1:0] d_distance;

   // geometry: normal, dot products, edge tests, limit check
   rti_front #(.C(COORD_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .vertex_a      (req_tdata[0*VEC_W +: VEC_W]),
      .vertex_b      (req_tdata[1*VEC_W +: VEC_W]),
      .vertex_c      (req_tdata[2*VEC_W +: VEC_W]),
      .ray_origin    (req_tdata[3*VEC_W +: VEC_W]),
      .ray_direction (req_tdata[4*VEC_W +: VEC_W]),
      .max_distance  (req_tdata[5*VEC_W +: DIST_W]),
      .out_valid     (f_valid),
      .out_full      (q_full),
      .out_hit       (f_hit),
      .out_num_mag   (f_num_mag),
      .out_den_mag   (f_den_mag)
   );

   // push whenever the last geometry stage holds an item and there is room
   assign q_push = f_valid && !q_full;
   assign q_pop  = !q_empty && d_ready;

   rti_fifo #(.W(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({f_hit, f_den_mag, f_num_mag}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // t = num / den in Q16.16, forced to zero on a miss
   rti_div #(.NW(NW)) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (!q_empty),
      .in_ready     (d_ready),
      .in_hit       (q_out[QDW-1]),
      .in_num_mag   (q_out[NW-1:0]),
      .in_den_mag   (q_out[2*NW-1:NW]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_hit      (d_hit),
      .out_distance (d_distance)
   );

   assign rsp_tdata = {(RSP_W - DIST_W - 1)'(0), d_distance, d_hit};

endmodule

// ===== hw/rtl/rti_mul.sv =====
module rti_mul #(
   parameter int AW    = 8,
   parameter int BW    = 8,
   parameter int NSTEP = 2
) (
   input  logic                    clock,
   input  logic                    ce,
   input  logic signed [AW-1:0]    a,
   input  logic signed [BW-1:0]    b,
   output logic signed [AW+BW-1:0] p
);

   // registers in order: operand register, NSTEP partial products, sign fix
   localparam int DW = (BW + NSTEP - 1) / NSTEP;
   localparam int XB = DW * NSTEP;
   localparam int PW = AW + BW;

   logic [AW-1:0]    ma_in;
   logic [BW-1:0]    mb_mag;
   logic [XB-1:0]    mb_in;
   logic             neg_in;
   logic [AW-1:0]    a_ff   [NSTEP];
   logic [XB-1:0]    b_ff   [NSTEP];
   logic             neg_ff [NSTEP+1];
   logic [PW-1:0]    acc_ff [NSTEP+1];
   logic [AW+DW-1:0] pp     [NSTEP];
   logic [PW-1:0]    acc_in [NSTEP];
   logic [PW-1:0]    p_ff;

   assign ma_in  = a[AW-1] ? $unsigned(-a) : $unsigned(a);
   assign mb_mag = b[BW-1] ? $unsigned(-b) : $unsigned(b);
   assign mb_in  = XB'(mb_mag);
   assign neg_in = a[AW-1] ^ b[BW-1];

   // one digit of b per step
   always_comb begin
      for (int k = 0; k < NSTEP; k++) begin
         pp[k]     = (AW+DW)'(a_ff[k]) * (AW+DW)'(b_ff[k][k*DW +: DW]);
         acc_in[k] = acc_ff[k] + (PW'(pp[k]) << (k*DW));
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         a_ff[0]   <= ma_in;
         b_ff[0]   <= mb_in;
         neg_ff[0] <= neg_in;
         acc_ff[0] <= '0;
         for (int k = 1; k < NSTEP; k++) begin
            a_ff[k] <= a_ff[k-1];
            b_ff[k] <= b_ff[k-1];
         end
         for (int k = 1; k <= NSTEP; k++) begin
            neg_ff[k] <= neg_ff[k-1];
            acc_ff[k] <= acc_in[k-1];
         end
         p_ff <= neg_ff[NSTEP] ? -acc_ff[NSTEP] : acc_ff[NSTEP];
      end
   end

   assign p = signed'(p_ff);

endmodule

// ===== hw/rtl/rti_fifo.sv =====
module rti_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/rti_front.sv =====
module rti_front import rti_pkg::*; #(
   parameter int C = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [VEC_W-1:0]     vertex_a,
   input  logic [VEC_W-1:0]     vertex_b,
   input  logic [VEC_W-1:0]     vertex_c,
   input  logic [VEC_W-1:0]     ray_origin,
   input  logic [VEC_W-1:0]     ray_direction,
   input  logic [DIST_W-1:0]    max_distance,
   output logic                 out_valid,
   input  logic                 out_full,
   output logic                 out_hit,
   output logic [3*C+5:0]       out_num_mag,
   output logic [3*C+5:0]       out_den_mag
);

   localparam int DW1 = C + 1;
   localparam int PW1 = 2 * C + 2;
   localparam int XW  = 2 * C + 3;
   localparam int NW  = 3 * C + 6;
   localparam int EW  = 4 * C + 8;
   localparam int QW  = NW + EW;
   localparam int TW  = QW + 1;
   localparam int LW  = NW + DIST_W + 1;
   localparam int PWD = 3 * C;
   localparam int NS1 = 2;
   localparam int NS2 = 4;
   localparam int L1  = NS1 + 2;
   localparam int L2  = NS2 + 2;
   localparam int FL  = 5 + L1 + L2;

   logic ce;
   logic v_ff [FL];

   logic [VEC_W-1:0]     fld [5];
   logic [VEC_W+PWD-1:0] ext [5];
   logic signed [C-1:0]  co  [5][3];

   // stage A: edges and offsets
   logic signed [DW1-1:0] e_in   [3][3];
   logic signed [DW1-1:0] ov_in  [3][3];
   logic signed [DW1-1:0] ac_in  [3];
   logic signed [DW1-1:0] ao_in  [3];
   logic signed [DW1-1:0] e_a_ff  [3][3];
   logic signed [DW1-1:0] ov_a_ff [3][3];
   logic signed [DW1-1:0] ac_a_ff [3];
   logic signed [DW1-1:0] ao_a_ff [3];
   logic signed [DW1-1:0] d_a_ff  [3];
   logic [DIST_W-1:0]     lim_a_ff;

   // stage B: cross product halves
   logic signed [DW1-1:0] xp [7][3];
   logic signed [DW1-1:0] xq [7][3];
   logic signed [PW1-1:0] pl_b_ff [7][3];
   logic signed [PW1-1:0] pr_b_ff [7][3];
   logic signed [DW1-1:0] ao_b_ff [3];
   logic signed [DW1-1:0] d_b_ff  [3];
   logic [DIST_W-1:0]     lim_b_ff;

   // stage C: normal, edge crosses
   logic signed [XW-1:0]  x_c_ff  [7][3];
   logic signed [DW1-1:0] ao_c_ff [3];
   logic signed [DW1-1:0] d_c_ff  [3];
   logic [DIST_W-1:0]     lim_c_ff;

   // dot product terms
   logic signed [XW-1:0]   mb1  [8][3];
   logic signed [2*XW-1:0] m1_p [8][3];
   logic [DIST_W-1:0]      lim_m1_ff [L1];

   // stage D: dot sums
   logic signed [EW-1:0] s_d_ff [8];
   logic [DIST_W-1:0]    lim_d_ff;

   // edge and limit products
   logic signed [QW-1:0] q0_p [3];
   logic signed [QW-1:0] q1_p [3];
   logic signed [LW-1:0] lp;
   logic signed [NW-1:0] den_m2_ff [L2];
   logic signed [NW-1:0] num_m2_ff [L2];

   // stage E: decision
   logic signed [TW-1:0] t_sum [3];
   logic [2:0]           side_ok;
   logic signed [NW-1:0] den_e, num_e;
   logic [NW-1:0]        an_c, ad_c;
   logic [LW-1:0]        lhs, rhs;
   logic                 hit_in;
   logic                 hit_e_ff;
   logic [NW-1:0]        an_e_ff, ad_e_ff;

   assign ce       = !v_ff[FL-1] || !out_full;
   assign in_ready = ce;

   assign fld[0] = vertex_a;
   assign fld[1] = vertex_b;
   assign fld[2] = vertex_c;
   assign fld[3] = ray_origin;
   assign fld[4] = ray_direction;

   always_comb begin
      for (int f = 0; f < 5; f++) begin
         ext[f] = {{PWD{1'b0}}, fld[f]};
         for (int i = 0; i < 3; i++) begin
            co[f][i] = signed'(ext[f][i*C +: C]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         e_in[0][i]  = DW1'(co[1][i]) - DW1'(co[0][i]);
         e_in[1][i]  = DW1'(co[2][i]) - DW1'(co[1][i]);
         e_in[2][i]  = DW1'(co[0][i]) - DW1'(co[2][i]);
         ac_in[i]    = DW1'(co[2][i]) - DW1'(co[0][i]);
         ao_in[i]    = DW1'(co[0][i]) - DW1'(co[3][i]);
         for (int k = 0; k < 3; k++) begin
            ov_in[k][i] = DW1'(co[3][i]) - DW1'(co[k][i]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xp[0][i] = e_a_ff[0][i];
         xq[0][i] = ac_a_ff[i];
         for (int k = 0; k < 3; k++) begin
            xp[1+k][i] = e_a_ff[k][i];
            xq[1+k][i] = ov_a_ff[k][i];
            xp[4+k][i] = e_a_ff[k][i];
            xq[4+k][i] = d_a_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mb1[0][i] = XW'(d_c_ff[i]);
         mb1[1][i] = XW'(ao_c_ff[i]);
         for (int g = 2; g < 8; g++) begin
            mb1[g][i] = x_c_ff[g-1][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FL; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (ce) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < FL; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         e_a_ff   <= e_in;
         ov_a_ff  <= ov_in;
         ac_a_ff  <= ac_in;
         ao_a_ff  <= ao_in;
         lim_a_ff <= max_distance;
         for (int i = 0; i < 3; i++) begin
            d_a_ff[i] <= DW1'(co[4][i]);
         end

         for (int j = 0; j < 7; j++) begin
            for (int i = 0; i < 3; i++) begin
               pl_b_ff[j][i] <= PW1'(xp[j][(i+1)%3]) * PW1'(xq[j][(i+2)%3]);
               pr_b_ff[j][i] <= PW1'(xp[j][(i+2)%3]) * PW1'(xq[j][(i+1)%3]);
            end
         end
         ao_b_ff  <= ao_a_ff;
         d_b_ff   <= d_a_ff;
         lim_b_ff <= lim_a_ff;

         for (int j = 0; j < 7; j++) begin
            for (int i = 0; i < 3; i++) begin
               x_c_ff[j][i] <= XW'(pl_b_ff[j][i]) - XW'(pr_b_ff[j][i]);
            end
         end
         ao_c_ff  <= ao_b_ff;
         d_c_ff   <= d_b_ff;
         lim_c_ff <= lim_b_ff;

         lim_m1_ff[0] <= lim_c_ff;
         for (int k = 1; k < L1; k++) begin
            lim_m1_ff[k] <= lim_m1_ff[k-1];
         end

         for (int g = 0; g < 8; g++) begin
            s_d_ff[g] <= EW'(m1_p[g][0]) + EW'(m1_p[g][1]) + EW'(m1_p[g][2]);
         end
         lim_d_ff <= lim_m1_ff[L1-1];

         den_m2_ff[0] <= NW'(s_d_ff[0]);
         num_m2_ff[0] <= NW'(s_d_ff[1]);
         for (int k = 1; k < L2; k++) begin
            den_m2_ff[k] <= den_m2_ff[k-1];
            num_m2_ff[k] <= num_m2_ff[k-1];
         end

         hit_e_ff <= hit_in;
         an_e_ff  <= an_c;
         ad_e_ff  <= ad_c;
      end
   end

   for (genvar g = 0; g < 8; g++) begin : g_dot
      for (genvar i = 0; i < 3; i++) begin : g_term
         rti_mul #(.AW(XW), .BW(XW), .NSTEP(NS1)) u_mul (
            .clock (clock),
            .ce    (ce),
            .a     (x_c_ff[0][i]),
            .b     (mb1[g][i]),
            .p     (m1_p[g][i])
         );
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_edge
      rti_mul #(.AW(EW), .BW(NW), .NSTEP(NS2)) u_mul_den (
         .clock (clock),
         .ce    (ce),
         .a     (s_d_ff[2+k]),
         .b     (NW'(s_d_ff[0])),
         .p     (q0_p[k])
      );
      rti_mul #(.AW(EW), .BW(NW), .NSTEP(NS2)) u_mul_num (
         .clock (clock),
         .ce    (ce),
         .a     (s_d_ff[5+k]),
         .b     (NW'(s_d_ff[1])),
         .p     (q1_p[k])
      );
   end

   rti_mul #(.AW(NW), .BW(DIST_W+1), .NSTEP(NS2)) u_mul_lim (
      .clock (clock),
      .ce    (ce),
      .a     (NW'(s_d_ff[0])),
      .b     (signed'({1'b0, lim_d_ff})),
      .p     (lp)
   );

   always_comb begin
      den_e = den_m2_ff[L2-1];
      num_e = num_m2_ff[L2-1];
      for (int k = 0; k < 3; k++) begin
         t_sum[k]   = TW'(q0_p[k]) + TW'(q1_p[k]);
         side_ok[k] = (t_sum[k] == '0) || (t_sum[k][TW-1] == den_e[NW-1]);
      end
      an_c   = num_e[NW-1] ? $unsigned(-num_e) : $unsigned(num_e);
      ad_c   = den_e[NW-1] ? $unsigned(-den_e) : $unsigned(den_e);
      lhs    = LW'(an_c) << FRAC_W;
      rhs    = lp[LW-1] ? $unsigned(-lp) : $unsigned(lp);
      hit_in = (den_e != '0)
             && ((num_e == '0) || (num_e[NW-1] == den_e[NW-1]))
             && (lhs < rhs)
             && (&side_ok);
   end

   assign out_valid   = v_ff[FL-1];
   assign out_hit     = hit_e_ff;
   assign out_num_mag = an_e_ff;
   assign out_den_mag = ad_e_ff;

endmodule

// ===== hw/rtl/rti_div.sv =====
module rti_div import rti_pkg::*; #(
   parameter int NW = 54
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_hit,
   input  logic [NW-1:0]     in_num_mag,
   input  logic [NW-1:0]     in_den_mag,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_hit,
   output logic [DIST_W-1:0] out_distance
);

   localparam int RW = NW + DIST_W;
   localparam int NS = DIST_W;

   logic              ce;
   logic              v_ff   [NS+1];
   logic              hit_ff [NS+1];
   logic [RW-1:0]     rem_ff [NS+1];
   logic [NW-1:0]     ad_ff  [NS];
   logic [DIST_W-1:0] q_ff   [NS+1];
   logic [RW-1:0]     s_c    [NS];
   logic              ge_c   [NS];
   logic [RW-1:0]     rem_in [NS];
   logic [DIST_W-1:0] q_in   [NS];

   assign ce       = !v_ff[NS] || out_ready;
   assign in_ready = ce;

   // restoring division, one quotient bit per stage, top bit first
   always_comb begin
      for (int j = 0; j < NS; j++) begin
         s_c[j]    = RW'(ad_ff[j]) << (NS - 1 - j);
         ge_c[j]   = (s_c[j] <= rem_ff[j]);
         rem_in[j] = ge_c[j] ? rem_ff[j] - s_c[j] : rem_ff[j];
         q_in[j]   = q_ff[j] | (DIST_W'(ge_c[j]) << (NS - 1 - j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NS; j++) begin
            v_ff[j] <= 1'b0;
         end
      end else if (ce) begin
         v_ff[0] <= in_valid;
         for (int j = 1; j <= NS; j++) begin
            v_ff[j] <= v_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         hit_ff[0] <= in_hit;
         rem_ff[0] <= RW'(in_num_mag) << FRAC_W;
         ad_ff[0]  <= in_den_mag;
         q_ff[0]   <= '0;
         for (int j = 1; j <= NS; j++) begin
            hit_ff[j] <= hit_ff[j-1];
            rem_ff[j] <= rem_in[j-1];
            q_ff[j]   <= q_in[j-1];
         end
         for (int j = 1; j < NS; j++) begin
            ad_ff[j] <= ad_ff[j-1];
         end
      end
   end

   assign out_valid    = v_ff[NS];
   assign out_hit      = hit_ff[NS];
   assign out_distance = hit_ff[NS] ? q_ff[NS] : '0;

endmodule

// ===== dv/testbench.sv =====
module testbench;
   import rti_pkg::*;

   localparam int COORD_W    = 16;
   localparam int ITEM_COUNT = 450;
   // cycles without any handshake before the run is abandoned
   localparam int IDLE_LIMIT = 4000;
   // geometry pipeline, queue and divider
   localparam int DRAIN_CYCLES = 80;

   typedef logic signed [255:0] wide_type;
   typedef longint vec3_type [3];

   typedef struct packed {
      logic        hit;
      logic [31:0] distance;
   } hit_result_type;

   // Exact hit predictor and in-order store of expected hit results.
   class IntersectBoard;
      hit_result_type awaited[$];
      int             mismatches;

      static function longint coord(logic [VEC_W-1:0] packed_vec, int idx);
         logic [COORD_W-1:0] word;
         word = packed_vec[idx*COORD_W +: COORD_W];
         return longint'($signed(word));
      endfunction

      static function vec3_type unpack_vec(logic [VEC_W-1:0] packed_vec);
         vec3_type v;
         for (int i = 0; i < 3; i++) v[i] = coord(packed_vec, i);
         return v;
      endfunction

      static function vec3_type sub3(vec3_type p, vec3_type q);
         vec3_type r;
         for (int i = 0; i < 3; i++) r[i] = p[i] - q[i];
         return r;
      endfunction

      static function vec3_type cross3(vec3_type p, vec3_type q);
         vec3_type r;
         r[0] = p[1] * q[2] - p[2] * q[1];
         r[1] = p[2] * q[0] - p[0] * q[2];
         r[2] = p[0] * q[1] - p[1] * q[0];
         return r;
      endfunction

      static function wide_type dot3(vec3_type p, vec3_type q);
         wide_type s;
         s = '0;
         for (int i = 0; i < 3; i++) s += wide_type'(p[i]) * wide_type'(q[i]);
         return s;
      endfunction

      // hit point on the inner side of the edge from v along e (zero counts as inside)
      static function bit on_inner_side(vec3_type n, vec3_type e, vec3_type v,
                                        vec3_type o, vec3_type d,
                                        wide_type num, wide_type den);
         wide_type side;
         side = den * dot3(n, cross3(e, sub3(o, v))) + num * dot3(n, cross3(e, d));
         return !((side < 0 && den > 0) || (side > 0 && den < 0));
      endfunction

      static function hit_result_type predict_hit(logic [REQ_W-1:0] req);
         vec3_type a, b, c, o, d, ab, bc, ca, n;
         wide_type den, num, num_abs, den_abs, scaled_num, limit_span;
         hit_result_type res;
         res = '0;
         a = unpack_vec(req[0*VEC_W +: VEC_W]);
         b = unpack_vec(req[1*VEC_W +: VEC_W]);
         c = unpack_vec(req[2*VEC_W +: VEC_W]);
         o = unpack_vec(req[3*VEC_W +: VEC_W]);
         d = unpack_vec(req[4*VEC_W +: VEC_W]);
         ab = sub3(b, a);
         bc = sub3(c, b);
         ca = sub3(a, c);
         n = cross3(ab, sub3(c, a));
         den = dot3(n, d);
         if (den == 0) return res;
         num = dot3(n, sub3(a, o));
         if (num != 0 && ((num < 0) != (den < 0))) return res;
         num_abs = (num < 0) ? -num : num;
         den_abs = (den < 0) ? -den : den;
         scaled_num = num_abs <<< FRAC_W;
         limit_span = wide_type'(longint'(req[5*VEC_W +: DIST_W])) * den_abs;
         if (scaled_num >= limit_span) return res;
         if (!on_inner_side(n, ab, a, o, d, num, den)) return res;
         if (!on_inner_side(n, bc, b, o, d, num, den)) return res;
         if (!on_inner_side(n, ca, c, o, d, num, den)) return res;
         res.hit = 1'b1;
         res.distance = 32'(scaled_num / den_abs);
         return res;
      endfunction

      function void note_request(logic [REQ_W-1:0] req);
         awaited = {awaited, predict_hit(req)};
      endfunction

      function void check_response(logic [RSP_W-1:0] rsp);
         hit_result_type want, got;
         got.hit = rsp[0];
         got.distance = rsp[32:1];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: hit=%0b distance=%h", got.hit, got.distance);
            return;
         end
         want = awaited.pop_front();
         if (got.hit !== want.hit || got.distance !== want.distance) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected hit=%0b distance=%h, got hit=%0b distance=%h",
                        want.hit, want.distance, got.hit, got.distance);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   IntersectBoard board = new;
   bit  hold_request = 1'b0;
   int  idle_cycles = 0;
   int  burst_left = 0;

   always #10 clock = ~clock;

   ray_triangle_intersect DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // check every accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   // abandon the run when nothing moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("ray_triangle_intersect verification failed");
         $finish;
      end
   end

   // result side: runs of full readiness, runs of random stalls, one long hold-off
   initial begin
      int run;
      int stall_pct;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         run = $urandom_range(1, 40);
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
         repeat (run) begin
            rsp_tready <= ($urandom_range(1, 100) > stall_pct);
            @(posedge clock);
         end
      end
   end

   function automatic logic [VEC_W-1:0] pack_vec(longint x, longint y, longint z);
      return {16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic logic [REQ_W-1:0] pack_request(logic [VEC_W-1:0] a, b, c, o, d,
                                                     logic [DIST_W-1:0] limit);
      return {limit, d, o, c, b, a};
   endfunction

   // offer one item, keep valid high within a burst, note it once accepted
   task automatic offer(logic [REQ_W-1:0] req);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= req;
      do @(posedge clock); while (!req_tready);
      board.note_request(req);
   endtask

   // triangle with a ray aimed at a point inside it; t is k plus a jitter
   task automatic offer_aimed(bit broken);
      longint a[3], b[3], c[3], p[3], d[3], o[3];
      int wa, wb, wc, k;
      logic [DIST_W-1:0] limit;
      wa = $urandom_range(0, 8); wb = $urandom_range(0, 8); wc = $urandom_range(1, 8);
      k = $urandom_range(0, 4);
      for (int i = 0; i < 3; i++) begin
         a[i] = $signed($urandom_range(0, 6000)) - 3000;
         b[i] = $signed($urandom_range(0, 6000)) - 3000;
         c[i] = $signed($urandom_range(0, 6000)) - 3000;
         p[i] = (a[i] * wa + b[i] * wb + c[i] * wc) / (wa + wb + wc);
         d[i] = $signed($urandom_range(0, 4000)) - 2000;
         if (broken) d[i] = -d[i];
         o[i] = p[i] - k * d[i];
         if ($urandom_range(0, 2) == 0) o[i] += $signed($urandom_range(0, 6)) - 3;
      end
      case ($urandom_range(0, 3))
         0: limit = $urandom;
         1: limit = 32'hFFFF_FFFF;
         2: limit = (k << FRAC_W) + $urandom_range(0, 1 << 17) - (1 << 16);
         default: limit = broken ? $urandom_range(0, 3) : ((k + 1) << FRAC_W);
      endcase
      offer(pack_request(pack_vec(a[0], a[1], a[2]), pack_vec(b[0], b[1], b[2]),
                         pack_vec(c[0], c[1], c[2]), pack_vec(o[0], o[1], o[2]),
                         pack_vec(d[0], d[1], d[2]), limit));
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [VEC_W-1:0] va, vb, vc, up;
      logic [REQ_W-1:0] noise;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      va = pack_vec(0, 0, 0);
      vb = pack_vec(256, 0, 0);
      vc = pack_vec(0, 256, 0);
      up = pack_vec(0, 0, 256);
      // all zero: degenerate triangle, all ones: every bit set (coordinates -1, limit at its top)
      offer('0);
      offer('1);
      // ray parallel to the plane
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 256), pack_vec(256, 0, 0), '1));
      // hit at t = 1, then the limit exactly at t and just above it
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 256), pack_vec(0, 0, -256), '1));
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 256), pack_vec(0, 0, -256),
                         32'h0001_0000));
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 256), pack_vec(0, 0, -256),
                         32'h0001_0001));
      // origin on the plane: t = 0, accepted unless the limit is zero
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 0), up, 32'h0000_0001));
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 0), up, 32'h0000_0000));
      // plane behind the origin: negative t
      offer(pack_request(va, vb, vc, pack_vec(50, 50, 256), up, '1));
      // hit points on a vertex and on each edge
      offer(pack_request(va, vb, vc, pack_vec(0, 0, 256), pack_vec(0, 0, -128), '1));
      offer(pack_request(va, vb, vc, pack_vec(128, 0, 256), pack_vec(0, 0, -256), '1));
      offer(pack_request(va, vb, vc, pack_vec(128, 128, 256), pack_vec(0, 0, -256), '1));
      offer(pack_request(va, vb, vc, pack_vec(0, 100, 256), pack_vec(0, 0, -256), '1));
      // just outside the hypotenuse, and a fractional t seen from below
      offer(pack_request(va, vb, vc, pack_vec(129, 128, 256), pack_vec(0, 0, -256), '1));
      offer(pack_request(va, vb, vc, pack_vec(30, 40, -300), pack_vec(1, 2, 7), '1));
      // extreme coordinates
      offer(pack_request(pack_vec(-32768, -32768, 0), pack_vec(32767, -32768, 0),
                         pack_vec(0, 32767, 0), pack_vec(0, 0, 32767),
                         pack_vec(0, 0, -32768), '1));
      offer(pack_request(pack_vec(-32768, -32768, 0), pack_vec(32767, -32768, 0),
                         pack_vec(0, 32767, 0), pack_vec(0, 0, -32768),
                         pack_vec(1, 1, 1), '1));

      for (int i = 0; i < ITEM_COUNT; i++) begin
         if (i == 150) hold_request = 1'b1;
         if (i == 300) wait_until_drained();
         case ($urandom_range(0, 9))
            0: begin
               for (int w = 0; w < REQ_W; w += 16) noise[w +: 16] = 16'($urandom);
               offer(noise);
            end
            1: offer_aimed(1'b1);
            default: offer_aimed(1'b0);
         endcase
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("ray_triangle_intersect verification clean");
      end else begin
         $display("ray_triangle_intersect verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/rti_pkg.sv
hw/rtl/rti_mul.sv
hw/rtl/rti_fifo.sv
hw/rtl/rti_front.sv
hw/rtl/rti_div.sv
hw/rtl/ray_triangle_intersect.sv
dv/testbench.sv
